@@ rtl/sbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsa_pkg
// Shared types and constants for the slab bitmap slot allocator.
// ----------------------------------------------------------------------------
package sbsa_pkg;

  localparam int NUM_CLASSES  = 18;
  localparam int BITMAP_WORDS = 32;
  localparam int WORD_BITS    = 64;
  localparam int HEADER_BYTES = 288;
  localparam int BLOCK_BYTES  = 65536;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [4:0]  size_class;
    logic [3:0]  block_index;
    logic [10:0] slot_index;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  granted_block;
    logic [10:0] granted_slot;
    logic [15:0] byte_offset;
    logic        block_released;
  } rsp_t;

  function automatic logic [11:0] class_bytes(input logic [4:0] c);
    if (c < 5'd16) return 12'({c, 5'b0}) + 12'd32;
    else if (c == 5'd16) return 12'd1024;
    else return 12'd2048;
  endfunction

  // capacity per class, (65536 - 288) / size, a constant table
  function automatic logic [11:0] class_capacity(input logic [4:0] c);
    case (c)
      5'd0:  return 12'd2039;
      5'd1:  return 12'd1019;
      5'd2:  return 12'd679;
      5'd3:  return 12'd509;
      5'd4:  return 12'd407;
      5'd5:  return 12'd339;
      5'd6:  return 12'd291;
      5'd7:  return 12'd254;
      5'd8:  return 12'd226;
      5'd9:  return 12'd203;
      5'd10: return 12'd185;
      5'd11: return 12'd169;
      5'd12: return 12'd156;
      5'd13: return 12'd145;
      5'd14: return 12'd135;
      5'd15: return 12'd127;
      5'd16: return 12'd63;
      default: return 12'd31;
    endcase
  endfunction

endpackage

@@ rtl/sbsa_req_if.sv @@
// ----------------------------------------------------------------------------
// sbsa_req_if / sbsa_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sbsa_req_if;
  logic              valid;
  logic              ready;
  sbsa_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sbsa_rsp_if;
  logic              valid;
  logic              ready;
  sbsa_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sbsa_ram.sv @@
// ----------------------------------------------------------------------------
// sbsa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/slab_bitmap_slot_allocator_core.sv @@
// Path from accept to result valid: free via S_RDWT, S_FREE and S_DONE;
//   rejected free or allocate with no free pool block straight to S_DONE;
//   allocate via S_RDWT, S_SCAN (past empty bitmap words) and S_DONE, with
//   S_FILL first writing a fresh pool block's bitmap. One transaction at a time;
//   the next request is taken only once the result has been accepted.
// Reset: list, pool and count state cleared at once; bitmap RAM not cleared.
// ----------------------------------------------------------------------------
// slab_bitmap_slot_allocator_core
// Slab slot allocator: per-class block lists, bitmap slot search in RAM.
// ----------------------------------------------------------------------------
module slab_bitmap_slot_allocator_core #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sbsa_req_if.sink    req,
  sbsa_rsp_if.source  rsp
);
  import sbsa_pkg::*;

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int AW = BW + 5;
  localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_RDWT  = 3'd5;

  logic [2:0]        state;
  logic [LW-1:0]     class_head [NUM_CLASSES];
  logic [LW-1:0]     next_link  [NUM_BLOCKS];
  logic [LW-1:0]     prev_link  [NUM_BLOCKS];
  logic              pool_busy  [NUM_BLOCKS];
  logic [10:0]       free_count [NUM_BLOCKS];
  logic [4:0]        block_class[NUM_BLOCKS];

  req_t              cur;
  logic [4:0]        cls;
  logic [BW-1:0]     blk;
  logic [4:0]        widx;
  logic [11:0]       cap;
  rsp_t              res;
  logic              res_valid;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [63:0]       wdata, rdata;

  sbsa_ram #(.WIDTH(64), .DEPTH(NUM_BLOCKS * BITMAP_WORDS)) u_bitmap (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [BW-1:0] pool_pick;
  logic          pool_any;
  always_comb begin
    pool_pick = '0;
    pool_any  = 1'b0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!pool_busy[i]) begin
        pool_pick = BW'(i);
        pool_any  = 1'b1;
      end
    end
  end

  logic [5:0] low_bit;
  always_comb begin
    low_bit = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (rdata[i]) low_bit = 6'(i);
    end
  end

  logic [11:0] wbase;
  logic [63:0] fill_word;
  assign wbase = {1'b0, widx, 6'b0};
  always_comb begin
    if (wbase + 12'd64 <= cap) fill_word = '1;
    else if (wbase < cap) fill_word = ~(64'hFFFF_FFFF_FFFF_FFFF << 6'(cap - wbase));
    else fill_word = '0;
  end

  logic [10:0] slot_a;
  logic [63:0] fmask;
  logic [LW-1:0] hd, pv, nx;
  assign slot_a = {widx, low_bit};
  assign fmask  = 64'd1 << cur.slot_index[5:0];
  assign hd     = class_head[cls];
  assign pv     = prev_link[blk];
  assign nx     = next_link[blk];

  logic [4:0]  cls_in;
  logic [20:0] offset_prod;
  assign cls_in = (req.payload.size_class >= 5'(NUM_CLASSES)) ? 5'(NUM_CLASSES - 1)
                                                              : req.payload.size_class;
  assign offset_prod = 21'(slot_a) * 21'(class_bytes(cls));

  assign req.ready   = (state == S_IDLE) && !res_valid;
  assign rsp.valid   = res_valid;
  assign rsp.payload = res;

  always_comb begin
    we    = 1'b0;
    waddr = {blk, widx};
    wdata = rdata;
    raddr = {blk, widx};
    case (state)
      S_FILL: begin
        we    = 1'b1;
        wdata = fill_word;
      end
      S_SCAN: begin
        if (rdata != '0) begin
          we    = 1'b1;
          wdata = rdata & ~(64'd1 << low_bit);
        end else begin
          raddr = {blk, 5'(widx + 5'd1)};
        end
      end
      S_FREE: begin
        if ((rdata & fmask) == '0) begin
          we    = 1'b1;
          wdata = rdata | fmask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) class_head[i] <= NIL;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        next_link[i]   <= NIL;
        prev_link[i]   <= NIL;
        pool_busy[i]   <= 1'b0;
        free_count[i]  <= '0;
        block_class[i] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur  <= req.payload;
            cls  <= cls_in;
            cap  <= class_capacity(cls_in);
            widx <= '0;
            res  <= '0;
            state <= S_DONE;
            if (req.payload.action == ACT_ALLOC) begin
              if (class_head[cls_in] != NIL) begin
                blk   <= BW'(class_head[cls_in]);
                state <= S_RDWT;
              end else if (pool_any) begin
                blk <= pool_pick;
                pool_busy[pool_pick]   <= 1'b1;
                block_class[pool_pick] <= cls_in;
                free_count[pool_pick]  <= 11'(class_capacity(cls_in));
                prev_link[pool_pick]   <= NIL;
                next_link[pool_pick]   <= NIL;
                class_head[cls_in]     <= LW'(pool_pick);
                state <= S_FILL;
              end else begin
                res.status <= 1'b1;
              end
            end else begin
              widx <= req.payload.slot_index[10:6];
              blk  <= BW'(req.payload.block_index);
              if (int'(req.payload.block_index) < NUM_BLOCKS
                  && pool_busy[BW'(req.payload.block_index)]
                  && block_class[BW'(req.payload.block_index)] == cls_in
                  && {1'b0, req.payload.slot_index} < class_capacity(cls_in))
                state <= S_RDWT;
            end
          end
        end
        S_FILL: begin
          widx <= widx + 5'd1;
          if (widx == 5'(BITMAP_WORDS - 1)) begin
            widx  <= '0;
            state <= S_RDWT;
          end
        end
        S_RDWT: begin
          state <= (cur.action == ACT_ALLOC) ? S_SCAN : S_FREE;
        end
        S_SCAN: begin
          if (rdata != '0) begin
            res.granted_block <= 4'(blk);
            res.granted_slot  <= slot_a;
            res.byte_offset   <= 16'(offset_prod + 21'(HEADER_BYTES));
            if (free_count[blk] <= 11'd1) begin
              free_count[blk] <= '0;
              if (nx != NIL) prev_link[BW'(nx)] <= NIL;
              class_head[cls] <= nx;
              next_link[blk]  <= NIL;
              prev_link[blk]  <= NIL;
            end else begin
              free_count[blk] <= free_count[blk] - 11'd1;
            end
            state <= S_DONE;
          end else if (widx == 5'(BITMAP_WORDS - 1)) begin
            res.status <= 1'b1;
            state      <= S_DONE;
          end else begin
            widx <= widx + 5'd1;
          end
        end
        S_FREE: begin
          state <= S_DONE;
          if ((rdata & fmask) == '0) begin
            free_count[blk] <= free_count[blk] + 11'd1;
            if (free_count[blk] == 11'd0) begin
              prev_link[blk] <= NIL;
              next_link[blk] <= hd;
              if (hd != NIL) prev_link[BW'(hd)] <= LW'(blk);
              class_head[cls] <= LW'(blk);
            end else if (12'(free_count[blk]) + 12'd1 == cap
                         && (pv != NIL || nx != NIL)) begin
              if (pv != NIL) next_link[BW'(pv)] <= nx;
              if (nx != NIL) prev_link[BW'(nx)] <= pv;
              if (hd == LW'(blk)) class_head[cls] <= nx;
              next_link[blk]   <= NIL;
              prev_link[blk]   <= NIL;
              pool_busy[blk]   <= 1'b0;
              free_count[blk]  <= '0;
              block_class[blk] <= '0;
              res.block_released <= 1'b1;
            end
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/sbsa_checker.sv @@
// ----------------------------------------------------------------------------
// sbsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sbsa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sbsa_pkg::rsp_t rsp_payload
);
  import sbsa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.status |->
      rsp_payload.granted_block == '0 && rsp_payload.granted_slot == '0
      && !rsp_payload.block_released)
    else $error("failed result carries data");

  a_release_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.block_released |->
      !rsp_payload.status && rsp_payload.byte_offset == '0)
    else $error("release on an allocate result");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_payload.status && !rsp_payload.block_released
      && rsp_payload.byte_offset != '0 |-> rsp_payload.byte_offset >= 16'(HEADER_BYTES))
    else $error("offset below header");
endmodule

bind slab_bitmap_slot_allocator_core sbsa_checker u_sbsa_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

@@ verif/tb_slab_bitmap_slot_allocator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slab_bitmap_slot_allocator_core
// Drives allocate and free requests into the slot allocator and checks every
// result against a behavioral slab model kept in the bench.
// ----------------------------------------------------------------------------
module tb_slab_bitmap_slot_allocator_core;
  import sbsa_pkg::*;

  localparam int NBLK = 16;
  localparam int NIL = NBLK;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbsa_req_if req_ch ();
  sbsa_rsp_if rsp_ch ();

  slab_bitmap_slot_allocator_core #(.NUM_BLOCKS(NBLK)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // slab model state
  int          head_of[NUM_CLASSES];
  int          nxt[NBLK];
  int          prv[NBLK];
  bit          busy[NBLK];
  int          nfree[NBLK];
  int          cls_of[NBLK];
  logic [63:0] bmap[NBLK][BITMAP_WORDS];

  // live slots for sensible frees: block*4096 + slot, per class
  int          live[NUM_CLASSES][$];

  rsp_t        pending_rsp[$];
  int          mismatches = 0;
  int          wdog = 0;
  bit          quiet = 1'b0;
  bit          tx_stall_on = 1'b1;

  function automatic int cls_size(int c);
    if (c < 16) return (c + 1) * 32;
    if (c == 16) return 1024;
    return 2048;
  endfunction

  function automatic int cls_cap(int c);
    return (BLOCK_BYTES - HEADER_BYTES) / cls_size(c);
  endfunction

  function automatic void slab_reset();
    for (int c = 0; c < NUM_CLASSES; c++) head_of[c] = NIL;
    for (int b = 0; b < NBLK; b++) begin
      nxt[b] = NIL; prv[b] = NIL; busy[b] = 0; nfree[b] = 0; cls_of[b] = 0;
      for (int w = 0; w < BITMAP_WORDS; w++) bmap[b][w] = '0;
    end
  endfunction

  function automatic void push_head(int c, int b);
    prv[b] = NIL;
    nxt[b] = head_of[c];
    if (head_of[c] != NIL) prv[head_of[c]] = b;
    head_of[c] = b;
  endfunction

  function automatic rsp_t slab_predict(req_t r);
    rsp_t o;
    int c, h, w, bt, slot, cap, b, nx, pv;
    o = '0;
    c = (r.size_class >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(r.size_class);
    cap = cls_cap(c);
    if (r.action == ACT_ALLOC) begin
      if (head_of[c] == NIL) begin
        b = NBLK;
        for (int i = NBLK - 1; i >= 0; i--) if (!busy[i]) b = i;
        if (b == NBLK) begin
          o.status = 1'b1;
          return o;
        end
        busy[b] = 1; cls_of[b] = c; nfree[b] = cap;
        for (int i = 0; i < BITMAP_WORDS; i++)
          for (int k = 0; k < 64; k++) bmap[b][i][k] = (i * 64 + k) < cap;
        push_head(c, b);
      end
      h = head_of[c];
      w = BITMAP_WORDS;
      for (int i = BITMAP_WORDS - 1; i >= 0; i--) if (bmap[h][i] != 0) w = i;
      if (w == BITMAP_WORDS) begin
        o.status = 1'b1;
        return o;
      end
      bt = 63;
      for (int k = 62; k >= 0; k--) if (bmap[h][w][k]) bt = k;
      bmap[h][w][bt] = 1'b0;
      if (nfree[h] > 0) nfree[h]--;
      if (nfree[h] == 0) begin
        nx = nxt[h];
        if (nx != NIL) prv[nx] = NIL;
        head_of[c] = nx;
        nxt[h] = NIL; prv[h] = NIL;
      end
      slot = w * 64 + bt;
      o.granted_block = h[3:0];
      o.granted_slot = slot[10:0];
      o.byte_offset = 16'(HEADER_BYTES + slot * cls_size(c));
      live[c].push_back(h * 4096 + slot);
    end else begin
      b = r.block_index;
      slot = r.slot_index;
      if (!busy[b] || cls_of[b] != c || slot >= cap) return o;
      if (bmap[b][slot / 64][slot % 64]) return o;
      bmap[b][slot / 64][slot % 64] = 1'b1;
      nfree[b]++;
      foreach (live[c][i]) if (live[c][i] == b * 4096 + slot) begin
        live[c].delete(i);
        break;
      end
      if (nfree[b] == 1) push_head(c, b);
      else if (nfree[b] == cap) begin
        pv = prv[b]; nx = nxt[b];
        if (pv != NIL || nx != NIL) begin
          if (pv != NIL) nxt[pv] = nx;
          if (nx != NIL) prv[nx] = pv;
          if (head_of[c] == b) head_of[c] = nx;
          nxt[b] = NIL; prv[b] = NIL; busy[b] = 0; nfree[b] = 0; cls_of[b] = 0;
          o.block_released = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // valid stays high after an accept until the next request or an idle gap
  task automatic send_req(logic act, int c, int b, int s);
    req_t r;
    if (!quiet && tx_stall_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    r.action = act;
    r.size_class = c[4:0];
    r.block_index = b[3:0];
    r.slot_index = s[10:0];
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(slab_predict(r));
  endtask

  task automatic send_alloc(int c);
    send_req(ACT_ALLOC, c, $urandom_range(0, 15), $urandom_range(0, 2047));
  endtask

  task automatic free_live(int c);
    int i, v;
    if (live[c].size() == 0) begin
      send_alloc(c);
      return;
    end
    i = $urandom_range(0, live[c].size() - 1);
    v = live[c][i];
    send_req(ACT_FREE, c, v / 4096, v % 4096);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result side: random stalls, compare each transaction
  always @(posedge clk) begin
    rsp_t got, want;
    if (rst) rsp_ch.ready <= 1'b0;
    else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st=%0d blk=%0d slot=%0d off=%0d rel=%0d",
                        " got st=%0d blk=%0d slot=%0d off=%0d rel=%0d"},
                       want.status, want.granted_block, want.granted_slot,
                       want.byte_offset, want.block_released,
                       got.status, got.granted_block, got.granted_slot,
                       got.byte_offset, got.block_released);
          end
        end
      end
      rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 5) != 0);
    end
  end

  int hold = 0;
  always @(posedge clk) begin
    if (!quiet && hold == 0 && $urandom_range(0, 15) == 0) hold = $urandom_range(1, 16);
    if (hold > 0) begin
      hold--;
      tx_stall_on <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst)
      wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else wdog <= wdog + 1;
  end

  task automatic test_directed();
    send_alloc(0);
    send_alloc(0);
    send_alloc(17);
    send_alloc(31);
    send_alloc(16);
    send_alloc(15);
    send_req(ACT_FREE, 0, 15, 2047);
    send_req(ACT_FREE, 0, 0, 2047);
    send_req(ACT_FREE, 3, 0, 0);
    send_req(ACT_FREE, 0, 0, 5);
    send_req(ACT_FREE, 0, 0, 1);
    send_req(ACT_FREE, 0, 0, 1);
    send_req(ACT_FREE, 0, 0, 0);
    send_req(ACT_FREE, 17, 1, 1);
    send_req(ACT_FREE, 24, 1, 0);
    send_req(ACT_FREE, 16, 2, 0);
    send_req(ACT_FREE, 15, 3, 0);
    drain();
  endtask

  // fill a class block, spilling into a second, then empty both
  task automatic test_block_release();
    for (int i = 0; i < 33; i++) send_alloc(17);
    while (live[17].size() != 0) free_live(17);
    drain();
  endtask

  task automatic test_pool_exhaust();
    for (int c = 0; c < 16; c++) send_alloc(c);
    send_alloc(16);
    send_alloc(17);
    send_alloc(16);
    for (int i = 0; i < 64; i++) send_alloc(16);
    send_alloc(17);
    for (int c = 0; c < NUM_CLASSES; c++) while (live[c].size() != 0) free_live(c);
    drain();
  endtask

  task automatic test_random(int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(12, 17);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_alloc(c);
        4, 5, 6, 7: free_live(c > 17 ? 17 : c);
        8: send_req(ACT_FREE, c, $urandom_range(0, 15), $urandom_range(0, 2047));
        default: send_req(ACT_FREE, c, $urandom_range(0, 15), $urandom_range(0, 63));
      endcase
    end
  endtask

  initial begin
    slab_reset();
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_block_release();
    test_pool_exhaust();
    test_random(1000);
    drain();
    quiet = 1'b1;
    test_random(500);
    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
